[rtl/lru_pr_pkg.sv]
// Shared constants, widths and controller/datapath types for the LRU page replacement unit.
package lru_pr_pkg;

   localparam int FRAMES_DEF     = 16;
   localparam int PAGE_BITS_DEF  = 16;
   localparam int STAMP_BITS_DEF = 32;

   localparam int PAGE_W  = 16;
   localparam int INDEX_W = 4;
   localparam int FAULT_W = 32;
   localparam int CFG_W   = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

[rtl/lru_pr_ifs.sv]
// Request, response and configuration channel interfaces.
interface lru_pr_req_if;
   logic                          valid;
   logic                          ready;
   logic [lru_pr_pkg::PAGE_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_pr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [lru_pr_pkg::INDEX_W-1:0] frame_index;
   logic                           evicted_valid;
   logic [lru_pr_pkg::PAGE_W-1:0]  evicted_page;
   logic [lru_pr_pkg::FAULT_W-1:0] fault_total;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

interface lru_pr_csr_if;
   logic                         valid;
   logic                         ready;
   logic [lru_pr_pkg::CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/lru_page_replacement_unit.sv]
// LRU page replacement unit, n = active frame count (frames_in_use clamped to 1..FRAMES).
// A new request is not accepted until the last one is committed, after the scan that reads
// one frame of the page and stamp memories per cycle for the match and oldest-stamp search;
// commit waits while an earlier response has not been taken.
// Reset: synchronous; valid bits, fill count and counters clear directly, no sweep.
module lru_page_replacement_unit #(
   parameter int FRAMES     = lru_pr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS  = lru_pr_pkg::PAGE_BITS_DEF,
   parameter int STAMP_BITS = lru_pr_pkg::STAMP_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   lru_pr_req_if.sink   req,
   lru_pr_rsp_if.source rsp,
   lru_pr_csr_if.sink   csr
);

   lru_pr_pkg::cmd_type    cmd;
   lru_pr_pkg::status_type status;

   assign csr.ready = 1'b1;

   lru_pr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd),
      .status    (status)
   );

   lru_pr_dp #(
      .FRAMES     (FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_page          (req.page_number),
      .csr_valid         (csr.valid),
      .csr_data          (csr.data),
      .rsp_hit           (rsp.hit),
      .rsp_frame_index   (rsp.frame_index),
      .rsp_evicted_valid (rsp.evicted_valid),
      .rsp_evicted_page  (rsp.evicted_page),
      .rsp_fault_total   (rsp.fault_total)
   );

   // a new response never overwrites one that has not been taken
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp.valid || rsp.ready))
      else $error("response loaded over a pending response");

   // commit only after the scan has drained
   a_commit_scanned: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.scan_done)
      else $error("commit before scan finished");

   // no request is taken while the scan is running
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> (!cmd.scan && !cmd.commit))
      else $error("request accepted while busy");

   // a response only appears after a completed scan
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(status.scan_done))
      else $error("response without a finished scan");

endmodule

[rtl/lru_pr_ctrl.sv]
// Controller: sequences accept, frame scan and commit, and owns the response valid flag.
module lru_pr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output lru_pr_pkg::cmd_type    cmd,
   input  lru_pr_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.start  = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/lru_pr_dp.sv]
// Datapath: frame memories, valid bits, scan pipeline, counters and response payload.
module lru_pr_dp #(
   parameter int FRAMES     = lru_pr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS  = lru_pr_pkg::PAGE_BITS_DEF,
   parameter int STAMP_BITS = lru_pr_pkg::STAMP_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lru_pr_pkg::cmd_type              cmd,
   output lru_pr_pkg::status_type           status,
   input  logic [lru_pr_pkg::PAGE_W-1:0]    req_page,
   input  logic                             csr_valid,
   input  logic [lru_pr_pkg::CFG_W-1:0]     csr_data,
   output logic                             rsp_hit,
   output logic [lru_pr_pkg::INDEX_W-1:0]   rsp_frame_index,
   output logic                             rsp_evicted_valid,
   output logic [lru_pr_pkg::PAGE_W-1:0]    rsp_evicted_page,
   output logic [lru_pr_pkg::FAULT_W-1:0]   rsp_fault_total
);

   localparam int IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW   = $clog2(FRAMES + 1);

   // frame memories
   logic [PAGE_BITS-1:0]  page_mem  [FRAMES];
   logic [STAMP_BITS-1:0] stamp_mem [FRAMES];
   logic [FRAMES-1:0]     valid_ff;

   logic [lru_pr_pkg::CFG_W-1:0]   cfg_ff;
   logic [CW-1:0]                  fill_ff;
   logic [STAMP_BITS-1:0]          ref_ff;
   logic [lru_pr_pkg::FAULT_W-1:0] fault_ff;

   // scan pipeline
   logic [PAGE_BITS-1:0]  page_ff;
   logic [CW-1:0]         addr_ff;
   logic                  cmp_en_ff;
   logic [IDXW-1:0]       cmp_idx_ff;
   logic [PAGE_BITS-1:0]  rd_page_ff;
   logic [STAMP_BITS-1:0] rd_stamp_ff;
   logic                  found_ff;
   logic [IDXW-1:0]       hit_idx_ff;
   logic                  first_ff;
   logic [STAMP_BITS-1:0] best_stamp_ff;
   logic [IDXW-1:0]       best_idx_ff;
   logic [PAGE_BITS-1:0]  best_page_ff;

   logic [CW-1:0]         n_active;
   logic                  rd_en;
   logic [STAMP_BITS-1:0] eff_stamp;
   logic                  cmp_valid;
   logic [IDXW-1:0]       slot;
   logic                  evict;

   always_comb begin
      if (cfg_ff == '0) begin
         n_active = CW'(1);
      end else if (int'(cfg_ff) > FRAMES) begin
         n_active = CW'(FRAMES);
      end else begin
         n_active = CW'(cfg_ff);
      end
   end

   assign rd_en            = cmd.scan && (addr_ff < n_active);
   assign status.scan_done = (addr_ff >= n_active) && !cmp_en_ff;
   assign cmp_valid        = valid_ff[cmp_idx_ff];
   assign eff_stamp        = cmp_valid ? rd_stamp_ff : '0;

   always_comb begin
      evict = 1'b0;
      if (found_ff) begin
         slot = hit_idx_ff;
      end else if (fill_ff < n_active) begin
         slot = fill_ff[IDXW-1:0];
      end else begin
         slot  = best_idx_ff;
         evict = valid_ff[best_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         page_mem[slot]  <= page_ff;
         stamp_mem[slot] <= ref_ff;
      end
      if (rd_en) begin
         rd_page_ff  <= page_mem[addr_ff[IDXW-1:0]];
         rd_stamp_ff <= stamp_mem[addr_ff[IDXW-1:0]];
      end
   end

   // scan control and search state
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         cmp_en_ff <= 1'b0;
      end else if (cmd.start) begin
         addr_ff   <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         cmp_en_ff <= rd_en;
         if (rd_en) begin
            addr_ff <= addr_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         page_ff  <= PAGE_BITS'(req_page);
         found_ff <= 1'b0;
         first_ff <= 1'b1;
      end else if (cmp_en_ff) begin
         if (cmp_valid && (rd_page_ff == page_ff) && !found_ff) begin
            found_ff   <= 1'b1;
            hit_idx_ff <= cmp_idx_ff;
         end
         // strict less keeps the lowest index among equal stamps
         if (first_ff || (eff_stamp < best_stamp_ff)) begin
            first_ff      <= 1'b0;
            best_stamp_ff <= eff_stamp;
            best_idx_ff   <= cmp_idx_ff;
            best_page_ff  <= rd_page_ff;
         end
      end
      if (rd_en) begin
         cmp_idx_ff <= addr_ff[IDXW-1:0];
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cfg_ff   <= lru_pr_pkg::CFG_RESET;
         fill_ff  <= '0;
         ref_ff   <= '0;
         fault_ff <= '0;
      end else begin
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
         if (cmd.commit) begin
            valid_ff[slot] <= 1'b1;
            if (!found_ff && (fill_ff < n_active)) begin
               fill_ff <= fill_ff + CW'(1);
            end
            if (!found_ff && (fault_ff != '1)) begin
               fault_ff <= fault_ff + lru_pr_pkg::FAULT_W'(1);
            end
            if (ref_ff != '1) begin
               ref_ff <= ref_ff + STAMP_BITS'(1);
            end
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit           <= found_ff;
         rsp_frame_index   <= lru_pr_pkg::INDEX_W'(slot);
         rsp_evicted_valid <= evict;
         rsp_evicted_page  <= evict ? lru_pr_pkg::PAGE_W'(best_page_ff) : '0;
         rsp_fault_total   <= (!found_ff && (fault_ff != '1)) ?
                              fault_ff + lru_pr_pkg::FAULT_W'(1) : fault_ff;
      end
   end

endmodule
